/* rtl/core/sorted_insert_list_core_macros.svh */
// assertion macros for the sorted insert list core
`ifndef SORTED_INSERT_LIST_CORE_MACROS_SVH
`define SORTED_INSERT_LIST_CORE_MACROS_SVH

`ifndef SYNTHESIS

// implication in the same cycle
`define SIL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the next cycle
`define SIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SIL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define SIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/sil_pkg.sv */
`timescale 1ns / 1ps

package sil_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int VALUE_W        = 32;
	localparam int POS_W          = 4;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic pop;
		logic push_new;
	} sil_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic head_ge;
	} sil_stat_t;

endpackage

/* rtl/core/sil_datapath.sv */
`timescale 1ns / 1ps

module sil_datapath import sil_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF,
	localparam int CW = $clog2(LIST_DEPTH + 1)
) (
	input  logic                      clk,
	input  sil_cmd_t                  cmd,
	input  logic [CW-1:0]             len,
	input  logic signed [VALUE_W-1:0] new_value,
	output sil_stat_t                 stat,
	output logic signed [VALUE_W-1:0] item_value
);

	logic [VALUE_W-1:0] cell_q [LIST_DEPTH];
	logic [VALUE_W-1:0] up_w   [LIST_DEPTH];
	logic signed [VALUE_W-1:0] v_q;
	logic signed [VALUE_W-1:0] item_value_q;

	// rotating queue: head leaves at cell 0, emitted value enters at the tail
	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
		if (k < LIST_DEPTH - 1) begin : g_up
			assign up_w[k] = cell_q[k+1];
		end else begin : g_end
			assign up_w[k] = cell_q[k];
		end

		always_ff @(posedge clk) begin
			if (cmd.pop) begin
				if (CW'(k + 1) == len) begin
					cell_q[k] <= cell_q[0];
				end else begin
					cell_q[k] <= up_w[k];
				end
			end else if (cmd.push_new && (CW'(k) == len)) begin
				cell_q[k] <= v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= new_value;
		end
		if (cmd.push_new) begin
			item_value_q <= v_q;
		end else if (cmd.pop) begin
			item_value_q <= cell_q[0];
		end
	end

	assign stat.head_ge = $signed(cell_q[0]) >= v_q;
	assign item_value   = item_value_q;

endmodule

/* rtl/core/sil_ctrl.sv */
`timescale 1ns / 1ps

module sil_ctrl import sil_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF,
	localparam int CW = $clog2(LIST_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sil_stat_t        stat,
	output sil_cmd_t         cmd,
	output logic [CW-1:0]    len,
	output logic             strobe,
	output logic [POS_W-1:0] item_position,
	output logic             last_item,
	output logic             dropped_full
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    len_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    total_q;
	logic             ins_q;
	logic             full_q;
	logic             strobe_q;
	logic [POS_W-1:0] pos_q;
	logic             last_q;
	logic             drop_q;

	logic emit;
	logic take_new;
	logic full_now;
	logic is_last;

	assign emit     = (state_q == ST_EMIT);
	assign take_new = !ins_q && ((rem_q == '0) || stat.head_ge);
	assign full_now = (len_q == CW'(LIST_DEPTH));
	assign is_last  = ((idx_q + CW'(1)) == total_q);

	assign cmd.load     = start && !emit;
	assign cmd.pop      = emit && !take_new;
	assign cmd.push_new = emit && take_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q    <= '0;
			rem_q    <= '0;
			idx_q    <= '0;
			total_q  <= '0;
			ins_q    <= 1'b0;
			full_q   <= 1'b0;
			strobe_q <= 1'b0;
			pos_q    <= '0;
			last_q   <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						full_q  <= full_now;
						ins_q   <= full_now;
						rem_q   <= len_q;
						idx_q   <= '0;
						total_q <= full_now ? len_q : len_q + CW'(1);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					pos_q    <= POS_W'(idx_q);
					last_q   <= is_last;
					drop_q   <= full_q;
					idx_q    <= idx_q + CW'(1);
					if (take_new) begin
						ins_q <= 1'b1;
						len_q <= len_q + CW'(1);
					end else begin
						rem_q <= rem_q - CW'(1);
					end
					if (is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = emit;
	assign len           = len_q;
	assign strobe        = strobe_q;
	assign item_position = pos_q;
	assign last_item     = last_q;
	assign dropped_full  = drop_q;

endmodule

/* rtl/core/sorted_insert_list_core.sv */
`timescale 1ns / 1ps
// channel   handshake          fields
// input     start, busy        new_value
// result    strobe             item_value, item_position, last_item, dropped_full
//
// an item is accepted when idle, then the entries after the insert pass one per cycle
// through the head comparator of the rotating queue; each result is registered
// and appears in the cycle after its step
// busy stays high while the entries pass; the receiver cannot stall
// reset empties the list; stored values are left as they are

`include "sorted_insert_list_core_macros.svh"

module sorted_insert_list_core import sil_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] new_value,
	output logic                      strobe,
	output logic signed [VALUE_W-1:0] item_value,
	output logic [POS_W-1:0]          item_position,
	output logic                      last_item,
	output logic                      dropped_full
);

	localparam int CW = $clog2(LIST_DEPTH + 1);

	sil_cmd_t      cmd;
	sil_stat_t     stat;
	logic [CW-1:0] len;

	sil_ctrl #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.stat         (stat),
		.cmd          (cmd),
		.len          (len),
		.strobe       (strobe),
		.item_position(item_position),
		.last_item    (last_item),
		.dropped_full (dropped_full)
	);

	sil_datapath #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.len       (len),
		.new_value (new_value),
		.stat      (stat),
		.item_value(item_value)
	);

	`SIL_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted item did not start")
	`SIL_ASSERT_NEXT(a_strobe_src, clk, arst_n, !busy, !strobe, "result without a step")
	`SIL_ASSERT_SAME(a_last_strobe, clk, arst_n, last_item, strobe, "last marker without result")
	`SIL_ASSERT_NEXT(a_burst, clk, arst_n, strobe && !last_item, strobe, "gap inside a list")

endmodule
